/* hw/rtl/glob_wildcard_matcher_defines.svh */
// ----------------------------------------------------------------------------
// Glob wildcard matcher assertion macros
// Shared concurrent assertion forms for the matcher checker.
// ----------------------------------------------------------------------------
`ifndef GLOB_WILDCARD_MATCHER_DEFINES_SVH
`define GLOB_WILDCARD_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define GWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glob matcher check failed");

// Next-cycle implication, disabled while in reset.
`define GWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glob matcher check failed");

`endif

/* hw/rtl/gwm_pkg.sv */
// ----------------------------------------------------------------------------
// Glob wildcard matcher package
// Constants, register codes and cell link types shared by the matcher.
// ----------------------------------------------------------------------------
package gwm_pkg;

  localparam int unsigned GWM_PATTERN_MAX = 16;
  localparam int unsigned GWM_REG_BYTES   = 16;

  localparam logic [7:0] GWM_ESC_BYTE   = 8'h5C;
  localparam logic [7:0] GWM_STAR_BYTE  = 8'h2A;
  localparam logic [7:0] GWM_QMARK_BYTE = 8'h3F;

  localparam int unsigned GWM_DATA_W = 64;
  localparam int unsigned GWM_ADDR_W = 5;
  localparam int unsigned GWM_LEN_W  = 5;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] GWM_REG_PAT_LO  = 2'd0;
  localparam logic [1:0] GWM_REG_PAT_HI  = 2'd1;
  localparam logic [1:0] GWM_REG_PAT_LEN = 2'd2;

  // Signals handed from one cell to its right neighbor.
  typedef struct packed {
    logic in_use;    // position lies inside the effective pattern
    logic start_on;  // start set closure carry
    logic close;     // star closure carry of the next set
    logic step1;     // advance by one position
    logic step2;     // escaped literal hit, lands two positions on
    logic hop;       // step2 of the cell two to the left, passing through
  } gwm_link_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic       restart;  // active set reads as the start set
    logic       advance;  // a character transfer updates the set
    logic [7:0] subj;
  } gwm_ctl_t;

endpackage

/* hw/rtl/gwm_ifs.sv */
// ----------------------------------------------------------------------------
// Glob wildcard matcher channels
// Valid/ready stream interfaces for subject characters and match results.
// ----------------------------------------------------------------------------
interface gwm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] subject_char;
  logic       end_of_subject;

  modport source (output valid, subject_char, end_of_subject, input ready);
  modport sink   (input valid, subject_char, end_of_subject, output ready);
endinterface

interface gwm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

/* hw/rtl/gwm_cfg.sv */
// ----------------------------------------------------------------------------
// Glob wildcard matcher configuration registers
// APB-style register file holding the pattern bytes and the pattern length.
// ----------------------------------------------------------------------------
module gwm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gwm_pkg::GWM_ADDR_W-1:0]   paddr,
  input  logic [gwm_pkg::GWM_DATA_W-1:0]   pwdata,
  output logic [gwm_pkg::GWM_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [gwm_pkg::GWM_DATA_W-1:0]   pat_lo,
  output logic [gwm_pkg::GWM_DATA_W-1:0]   pat_hi,
  output logic [gwm_pkg::GWM_LEN_W-1:0]    pat_len,
  output logic                             wr_hit
);
  import gwm_pkg::*;

  logic [GWM_DATA_W-1:0] pat_lo_r, pat_lo_nxt;
  logic [GWM_DATA_W-1:0] pat_hi_r, pat_hi_nxt;
  logic [GWM_LEN_W-1:0]  pat_len_r, pat_len_nxt;
  logic [1:0]            reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    pat_lo_nxt  = pat_lo_r;
    pat_hi_nxt  = pat_hi_r;
    pat_len_nxt = pat_len_r;
    wr_hit      = 1'b0;
    if (wr_en) begin
      unique case (reg_idx)
        GWM_REG_PAT_LO: begin
          pat_lo_nxt = pwdata;
          wr_hit     = 1'b1;
        end
        GWM_REG_PAT_HI: begin
          pat_hi_nxt = pwdata;
          wr_hit     = 1'b1;
        end
        GWM_REG_PAT_LEN: begin
          pat_len_nxt = pwdata[GWM_LEN_W-1:0];
          wr_hit      = 1'b1;
        end
        default: begin
          wr_hit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      GWM_REG_PAT_LO:  prdata = pat_lo_r;
      GWM_REG_PAT_HI:  prdata = pat_hi_r;
      GWM_REG_PAT_LEN: prdata = {{(GWM_DATA_W-GWM_LEN_W){1'b0}}, pat_len_r};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= '0;
    end else begin
      pat_lo_r  <= pat_lo_nxt;
      pat_hi_r  <= pat_hi_nxt;
      pat_len_r <= pat_len_nxt;
    end
  end

  assign pat_lo  = pat_lo_r;
  assign pat_hi  = pat_hi_r;
  assign pat_len = pat_len_r;

endmodule

/* hw/rtl/gwm_cell.sv */
// ----------------------------------------------------------------------------
// Glob wildcard matcher position cell
// Holds one bit of the active position set and decodes its pattern byte.
// ----------------------------------------------------------------------------
module gwm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  gwm_pkg::gwm_ctl_t   ctl,
  input  logic [7:0]          pat_byte,
  input  logic [7:0]          next_byte,
  input  logic                lt_n,
  input  logic                next_lt_n,
  input  gwm_pkg::gwm_link_t  link_in,
  output gwm_pkg::gwm_link_t  link_out,
  output logic                match_tap
);
  import gwm_pkg::*;

  logic active_r, active_nxt;
  logic eff;
  logic in_use, in_use_next;
  logic is_esc, is_star, is_qm, is_lit;
  logic start_here;

  assign in_use      = link_in.in_use && lt_n && (pat_byte != 8'h00);
  assign in_use_next = in_use && next_lt_n && (next_byte != 8'h00);

  // backslash escapes only a following star or question mark
  assign is_esc  = in_use_next && (pat_byte == GWM_ESC_BYTE) &&
                   ((next_byte == GWM_STAR_BYTE) || (next_byte == GWM_QMARK_BYTE));
  assign is_star = in_use && !is_esc && (pat_byte == GWM_STAR_BYTE);
  assign is_qm   = in_use && !is_esc && (pat_byte == GWM_QMARK_BYTE);
  assign is_lit  = in_use && !is_esc && !is_star && !is_qm && (pat_byte == ctl.subj);

  assign start_here = link_in.start_on;
  assign eff        = ctl.restart ? start_here : active_r;

  // star keeps its own position; closure ripples in from the left
  assign active_nxt = (eff && is_star) || link_in.step1 || link_in.hop || link_in.close;

  assign link_out.in_use   = in_use;
  assign link_out.start_on = start_here && is_star;
  assign link_out.close    = active_nxt && is_star;
  assign link_out.step1    = eff && (is_qm || is_lit);
  assign link_out.step2    = eff && is_esc && (next_byte == ctl.subj);
  assign link_out.hop      = link_in.step2;

  // this position is the end of the effective pattern
  assign match_tap = eff && link_in.in_use && !in_use;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (ctl.advance) begin
      active_r <= active_nxt;
    end
  end

endmodule

/* hw/rtl/glob_wildcard_matcher.sv */
// ----------------------------------------------------------------------------
// Glob wildcard matcher
// Streams a subject string one character per transfer against a glob
// pattern held in registers; an end transfer returns the match result.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------
//   in_ch    | in  | valid / ready      | subject_char[7:0], end_of_subject
//   out_ch   | out | valid / ready      | matched
//   cfg      | in  | psel/penable/pready| paddr[4:0], pwdata/prdata[63:0]
//
// One subject transfer per cycle unless in_ch stalls; the end transfer's result
// shows in the output register in the next cycle. The critical path is the star
// closure that ripples through the row of PATTERN_MAX+1 position cells.
// Synchronous reset leaves an empty pattern and the start set; no clear pass.
// in_ch stalls only while a result sits in the output register unaccepted.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher #(
  parameter int unsigned PATTERN_MAX = gwm_pkg::GWM_PATTERN_MAX
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gwm_in_if.sink                          in_ch,
  gwm_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gwm_pkg::GWM_ADDR_W-1:0]  paddr,
  input  logic [gwm_pkg::GWM_DATA_W-1:0]  pwdata,
  output logic [gwm_pkg::GWM_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import gwm_pkg::*;

  logic [GWM_DATA_W-1:0]   pat_lo;
  logic [GWM_DATA_W-1:0]   pat_hi;
  logic [GWM_LEN_W-1:0]    pat_len;
  logic                    cfg_wr;
  logic [2*GWM_DATA_W-1:0] pat_w;

  logic [7:0]      byte_w [0:PATTERN_MAX+1];
  logic            lt_n_w [0:PATTERN_MAX+1];
  gwm_link_t       link_w [0:PATTERN_MAX+1];
  logic [PATTERN_MAX:0] tap_w;

  gwm_ctl_t ctl;
  logic     in_xfer;
  logic     restart_r, restart_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     matched_r, matched_nxt;

  gwm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pat_lo  (pat_lo),
    .pat_hi  (pat_hi),
    .pat_len (pat_len),
    .wr_hit  (cfg_wr)
  );

  assign pat_w = {pat_hi, pat_lo};

  // position PATTERN_MAX is the tail cell; the extra slot past it is all zero
  for (genvar i = 0; i <= PATTERN_MAX + 1; i++) begin : g_decode
    if ((i < GWM_REG_BYTES) && (i < PATTERN_MAX)) begin : g_byte
      assign byte_w[i] = pat_w[8*i +: 8];
    end else begin : g_zero
      assign byte_w[i] = 8'h00;
    end
    assign lt_n_w[i] = (i < PATTERN_MAX) && (int'(pat_len) > i);
  end

  assign link_w[0] = '{in_use: 1'b1, start_on: 1'b1, close: 1'b0,
                       step1: 1'b0, step2: 1'b0, hop: 1'b0};

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign ctl.restart = restart_r;
  assign ctl.advance = in_xfer && !in_ch.end_of_subject;
  assign ctl.subj    = in_ch.subject_char;

  for (genvar i = 0; i <= PATTERN_MAX; i++) begin : g_cell
    gwm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .pat_byte  (byte_w[i]),
      .next_byte (byte_w[i+1]),
      .lt_n      (lt_n_w[i]),
      .next_lt_n (lt_n_w[i+1]),
      .link_in   (link_w[i]),
      .link_out  (link_w[i+1]),
      .match_tap (tap_w[i])
    );
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;

  always_comb begin
    restart_nxt   = restart_r;
    out_valid_nxt = out_valid_r;
    matched_nxt   = matched_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      restart_nxt = in_ch.end_of_subject;
      if (in_ch.end_of_subject) begin
        out_valid_nxt = 1'b1;
        matched_nxt   = |tap_w;
      end
    end
    if (cfg_wr) begin
      restart_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      restart_r   <= restart_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    matched_r <= matched_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.matched = matched_r;

endmodule

/* hw/rtl/gwm_checker.sv */
// ----------------------------------------------------------------------------
// Glob wildcard matcher checker
// Port-level assertions on the matcher's channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "glob_wildcard_matcher_defines.svh"

module gwm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_end,
  input logic out_valid,
  input logic out_ready,
  input logic out_matched
);

  logic end_xfer;
  assign end_xfer = in_valid && in_ready && in_end;

  // an end transfer always yields a result in the next cycle
  `GWM_ASSERT_NEXT(a_end_gives_result, end_xfer, out_valid)

  // a fresh result only ever follows an end transfer
  `GWM_ASSERT_NOW(a_no_spurious_result, $rose(out_valid), $past(end_xfer))

  // the input side is open whenever the output register is empty or drains
  `GWM_ASSERT_NOW(a_ready_when_free, !out_valid || out_ready, in_ready)

  // a stalled result holds
  `GWM_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
                   out_valid && $stable(out_matched))

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_end      (in_ch.end_of_subject),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_matched (out_ch.matched)
);
